/* hdl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, reset value, pipeline side-band types and the divider state type
// shared by the exponentiation pipeline and its modular multiply stages.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int MOD_WIDTH     = 14;
   localparam int EXP_WIDTH     = 16;
   // Barrett reciprocal floor(2^(2*MOD_WIDTH) / modulus) and product width.
   localparam int MU_WIDTH      = 2 * MOD_WIDTH;
   // A Barrett remainder stays below twice the modulus.
   localparam int RES_WIDTH     = MOD_WIDTH + 1;
   localparam int DIV_STEPS     = MU_WIDTH + 1;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);
   // One base reduction, then a square and a multiply per exponent bit.
   localparam int UNIT_COUNT    = 2 * EXP_WIDTH + 1;

   localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(4877);
   localparam logic [MOD_WIDTH-1:0] MOD_ONE       = MOD_WIDTH'(1);
   localparam logic [MOD_WIDTH-1:0] MOD_TWO       = MOD_WIDTH'(2);

   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } div_state_type;

   // Request context that travels alongside each multiply stage.
   typedef struct packed {
      logic                 vld;
      logic [MOD_WIDTH-1:0] base;
      logic [EXP_WIDTH-1:0] expo;
   } side_type;

   // Shared controls for every modular multiply unit.
   typedef struct packed {
      logic                 advance;
      logic [MOD_WIDTH-1:0] modulus;
      logic [MU_WIDTH-1:0]  mu;
   } mm_ctl_type;

endpackage

/* hdl/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation
// Pipelined square-and-multiply of base^exponent mod a configured modulus.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_base_value, req_exponent_value
//  rsp     | out       | rsp_valid, rsp_ready, rsp_power_residue
//  csr     | in        | csr_valid, csr_ready, csr_modulus
//
// One request is accepted per cycle while the divider is idle and no response
// waits; each passes through 33 four-stage Barrett multiply units in a row.
// After reset and after each modulus write, a bit-serial divider forms the
// reciprocal; no request is taken then.
// A stalled response freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module modular_exponentiation import mexp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [MOD_WIDTH-1:0] req_base_value,
   input  logic [EXP_WIDTH-1:0] req_exponent_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [MOD_WIDTH-1:0] rsp_power_residue,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [MOD_WIDTH-1:0] csr_modulus
);

   div_state_type              div_state_ff;
   div_state_type              div_state_in;
   logic [DIV_CNT_WIDTH-1:0]   div_cnt_ff;
   logic [RES_WIDTH-1:0]       div_rem_ff;
   logic [RES_WIDTH-1:0]       div_shift;
   logic [RES_WIDTH-1:0]       div_rem_in;
   logic                       div_ge;
   logic                       div_idle;
   logic [MOD_WIDTH-1:0]       modulus_ff;
   logic [MU_WIDTH-1:0]        mu_ff;
   logic                       csr_write;
   logic                       advance;
   mm_ctl_type                 ctl;

   logic     [MOD_WIDTH-1:0]   ua   [UNIT_COUNT];
   logic     [MOD_WIDTH-1:0]   ub   [UNIT_COUNT];
   side_type                   uin  [UNIT_COUNT];
   logic     [MOD_WIDTH-1:0]   ures [UNIT_COUNT];
   side_type                   uout [UNIT_COUNT];

   // Reciprocal divider: restoring division of 2^(2*MOD_WIDTH) by the modulus,
   // one quotient bit per cycle, shifted into mu_ff from the right.
   assign csr_write  = csr_valid && csr_ready;
   assign div_shift  = {div_rem_ff[MOD_WIDTH-1:0],
                        div_cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1)};
   assign div_ge     = div_shift >= {1'b0, modulus_ff};
   assign div_rem_in = div_ge ? div_shift - {1'b0, modulus_ff} : div_shift;

   always_comb begin
      div_state_in = div_state_ff;
      case (div_state_ff)
         DIV_IDLE: begin
            if (csr_write) begin
               div_state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (div_cnt_ff == '0) begin
               div_state_in = DIV_IDLE;
            end
         end
         default: div_state_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      case (div_state_ff)
         DIV_IDLE: div_idle = 1'b1;
         DIV_RUN:  div_idle = 1'b0;
         default:  div_idle = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_state_ff <= DIV_RUN;
         div_cnt_ff   <= DIV_CNT_WIDTH'(DIV_STEPS - 1);
         div_rem_ff   <= '0;
         modulus_ff   <= MODULUS_RESET;
      end else begin
         div_state_ff <= div_state_in;
         if (csr_write) begin
            modulus_ff <= csr_modulus;
            div_cnt_ff <= DIV_CNT_WIDTH'(DIV_STEPS - 1);
            div_rem_ff <= '0;
         end else if (div_state_ff == DIV_RUN) begin
            div_cnt_ff <= div_cnt_ff - DIV_CNT_WIDTH'(1);
            div_rem_ff <= div_rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_state_ff == DIV_RUN) begin
         mu_ff <= {mu_ff[MU_WIDTH-2:0], div_ge};
      end
   end

   assign csr_ready = div_idle;

   // The pipeline moves as one; it holds only while a response waits.
   assign rsp_valid         = uout[UNIT_COUNT-1].vld;
   assign rsp_power_residue = ures[UNIT_COUNT-1];
   assign advance           = !rsp_valid || rsp_ready;
   assign req_ready         = div_idle && advance;

   assign ctl.advance = advance;
   assign ctl.modulus = modulus_ff;
   assign ctl.mu      = mu_ff;

   genvar u;
   generate
      for (u = 0; u < UNIT_COUNT; u++) begin : g_unit
         if (u == 0) begin : g_reduce
            // Reduce the base by multiplying it with one.
            always_comb begin
               ua[u]       = req_base_value;
               ub[u]       = MOD_ONE;
               uin[u].vld  = req_valid && req_ready;
               uin[u].base = '0;
               uin[u].expo = req_exponent_value;
            end
         end else if (u == 1) begin : g_first_square
            // The accumulator starts at one; the reduced base joins the context.
            always_comb begin
               ua[u]       = MOD_ONE;
               ub[u]       = MOD_ONE;
               uin[u].vld  = uout[u-1].vld;
               uin[u].base = ures[u-1];
               uin[u].expo = uout[u-1].expo;
            end
         end else if ((u % 2) == 1) begin : g_square
            always_comb begin
               ua[u]  = ures[u-1];
               ub[u]  = ures[u-1];
               uin[u] = uout[u-1];
            end
         end else begin : g_multiply
            // Multiply by the base when the current exponent bit is set.
            always_comb begin
               ua[u]       = ures[u-1];
               ub[u]       = uout[u-1].expo[EXP_WIDTH-1] ? uout[u-1].base : MOD_ONE;
               uin[u].vld  = uout[u-1].vld;
               uin[u].base = uout[u-1].base;
               uin[u].expo = {uout[u-1].expo[EXP_WIDTH-2:0], 1'b0};
            end
         end

         mexp_mulmod u_mulmod (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .a_value   (ua[u]),
            .b_value   (ub[u]),
            .side_in   (uin[u]),
            .res_value (ures[u]),
            .side_out  (uout[u])
         );
      end
   endgenerate

endmodule

/* hdl/mexp_mulmod.sv */
// ----------------------------------------------------------------------------
// Modular multiply unit
// Four-stage Barrett multiply: product, quotient estimate, remainder,
// final correction. Request context is carried alongside each stage.
// ----------------------------------------------------------------------------
module mexp_mulmod import mexp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  mm_ctl_type           ctl,
   input  logic [MOD_WIDTH-1:0] a_value,
   input  logic [MOD_WIDTH-1:0] b_value,
   input  side_type             side_in,
   output logic [MOD_WIDTH-1:0] res_value,
   output side_type             side_out
);

   logic [MU_WIDTH-1:0]           prod_in;
   logic [MU_WIDTH-1:0]           prod_ff;
   logic [2*MU_WIDTH-1:0]         est_wide;
   logic [MU_WIDTH-1:0]           quot_in;
   logic [MU_WIDTH-1:0]           quot_ff;
   logic [RES_WIDTH-1:0]          low_ff;
   logic [MU_WIDTH+MOD_WIDTH-1:0] qm_wide;
   logic [RES_WIDTH-1:0]          rem_in;
   logic [RES_WIDTH-1:0]          rem_ff;
   logic [RES_WIDTH-1:0]          diff;
   logic [MOD_WIDTH-1:0]          res_in;
   logic [MOD_WIDTH-1:0]          res_ff;
   logic                          small_mod;
   side_type                      side1_ff;
   side_type                      side2_ff;
   side_type                      side3_ff;
   side_type                      side4_ff;

   assign prod_in  = MU_WIDTH'(a_value) * MU_WIDTH'(b_value);
   assign est_wide = (2*MU_WIDTH)'(prod_ff) * (2*MU_WIDTH)'(ctl.mu);
   assign quot_in  = est_wide[2*MU_WIDTH-1:MU_WIDTH];

   // The estimate is short by at most one, so only the low bits of the
   // remainder are needed.
   assign qm_wide = (MU_WIDTH+MOD_WIDTH)'(quot_ff) * (MU_WIDTH+MOD_WIDTH)'(ctl.modulus);
   assign rem_in  = low_ff - qm_wide[RES_WIDTH-1:0];

   assign small_mod = ctl.modulus < MOD_TWO;
   assign diff      = rem_ff - {1'b0, ctl.modulus};

   always_comb begin
      if (small_mod) begin
         res_in = '0;
      end else if (rem_ff >= {1'b0, ctl.modulus}) begin
         res_in = diff[MOD_WIDTH-1:0];
      end else begin
         res_in = rem_ff[MOD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         prod_ff <= prod_in;
         quot_ff <= quot_in;
         low_ff  <= prod_ff[RES_WIDTH-1:0];
         rem_ff  <= rem_in;
         res_ff  <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.vld <= 1'b0;
         side2_ff.vld <= 1'b0;
         side3_ff.vld <= 1'b0;
         side4_ff.vld <= 1'b0;
      end else if (ctl.advance) begin
         side1_ff <= side_in;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
         side4_ff <= side3_ff;
      end
   end

   assign res_value = res_ff;
   assign side_out  = side4_ff;

endmodule
